// ----- rtl/lsma_pkg.sv -----
package lsma_pkg;

  // Palette size and derived index width.
  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths.
  localparam int COLOR_W = 24;
  localparam int MULT_W  = 8;
  localparam int COUNT_W = 16;
  localparam int DIST_W  = 10;
  localparam int TOL_W   = 10;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [MULT_W-1:0]  mult_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [TOL_W-1:0]   tol_t;
  typedef logic [SLOT_W-1:0]  slot_idx_t;

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_DMULT = 1'b1;

  // Reset values.
  localparam tol_t   TOL_RESET  = 10'd3;
  localparam mult_t  MULT_RESET = 8'd28;
  localparam count_t COUNT_MAX  = 16'hFFFF;

  localparam logic [3:0][COLOR_W-1:0] BASE_PALETTE = {
    24'h5000C8, 24'hFFFA14, 24'h0A0AFF, 24'hFFFFFF
  };

  // Reset colour of a slot; slots beyond the base palette start black.
  function automatic color_t base_color(input int unsigned i);
    color_t c;
    c = '0;
    if (i < 4) begin
      c = BASE_PALETTE[i[1:0]];
    end
    return c;
  endfunction

  // One request as it leaves the input register.
  typedef struct packed {
    logic [1:0] kind;
    color_t     color;
    mult_t      mult;
    logic [1:0] slot;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0] chosen_slot;
    logic       newly_claimed;
    count_t     count_after;
  } res_t;

  // State update decided by the match logic.
  typedef struct packed {
    logic      cnt_we;
    slot_idx_t cnt_slot;
    count_t    cnt_val;
    logic      claim;
    color_t    color;
    mult_t     mult;
    logic      clear;
  } upd_t;

endpackage

// ----- rtl/lsma_match.sv -----
module lsma_match
  import lsma_pkg::*;
(
  input  req_t                     req,
  input  color_t [SLOT_COUNT-1:0]  slot_color,
  input  mult_t  [SLOT_COUNT-1:0]  slot_mult,
  input  count_t [SLOT_COUNT-1:0]  use_count,
  input  tol_t                     tol,
  input  mult_t                    dflt_mult,
  output res_t                     res,
  output upd_t                     upd
);

  function automatic logic [MULT_W-1:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // L1 distance from the request to every slot, side by side.
  dist_t [SLOT_COUNT-1:0] slot_dist;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_dist[i] = DIST_W'(abs_diff(req.color[23:16], slot_color[i][23:16]))
                   + DIST_W'(abs_diff(req.color[15:8],  slot_color[i][15:8]))
                   + DIST_W'(abs_diff(req.color[7:0],   slot_color[i][7:0]));
      if (req.mult != '0) begin
        slot_dist[i] = slot_dist[i] + DIST_W'(abs_diff(req.mult, slot_mult[i]));
      end
    end
  end

  // Nearest slot among slot 0 and the live slots, the lowest index winning ties, and the first free slot above slot 0.
  slot_idx_t best;
  dist_t     best_d;
  slot_idx_t free_slot;
  logic      free_found;

  always_comb begin
    best       = '0;
    best_d     = slot_dist[0];
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = 1; i < SLOT_COUNT; i++) begin
      if (use_count[i] != '0 && slot_dist[i] < best_d) begin
        best   = SLOT_W'(i);
        best_d = slot_dist[i];
      end
      if (!free_found && use_count[i] == '0) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // Decide the result and the state update.
  slot_idx_t free_idx;
  logic      free_ok;
  count_t    best_inc;
  count_t    free_dec;

  assign free_idx = SLOT_W'(req.slot);
  assign free_ok  = (32'(req.slot) < SLOT_COUNT);
  assign best_inc = (use_count[best] < COUNT_MAX) ? use_count[best] + 1'b1 : use_count[best];
  assign free_dec = (use_count[free_idx] > '0) ? use_count[free_idx] - 1'b1
                                               : use_count[free_idx];

  always_comb begin
    res = '0;
    upd = '0;
    upd.color = req.color;
    upd.mult  = (req.mult != '0) ? req.mult : dflt_mult;
    case (req.kind)
      KIND_ALLOC: begin
        if (32'(best_d) < 32'(tol) || !free_found) begin
          upd.cnt_we      = 1'b1;
          upd.cnt_slot    = best;
          upd.cnt_val     = best_inc;
          res.chosen_slot = 2'(best);
          res.count_after = best_inc;
        end else begin
          upd.cnt_we        = 1'b1;
          upd.claim         = 1'b1;
          upd.cnt_slot      = free_slot;
          upd.cnt_val       = count_t'(1);
          res.chosen_slot   = 2'(free_slot);
          res.newly_claimed = 1'b1;
          res.count_after   = count_t'(1);
        end
      end
      KIND_FREE: begin
        res.chosen_slot = req.slot;
        if (free_ok) begin
          upd.cnt_we      = 1'b1;
          upd.cnt_slot    = free_idx;
          upd.cnt_val     = free_dec;
          res.count_after = free_dec;
        end
      end
      KIND_CLEAR: begin
        upd.clear       = 1'b1;
        res.count_after = use_count[0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- rtl/lsma_state.sv -----
module lsma_state
  import lsma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     apply,
  input  upd_t                     upd,
  output color_t [SLOT_COUNT-1:0]  slot_color,
  output mult_t  [SLOT_COUNT-1:0]  slot_mult,
  output count_t [SLOT_COUNT-1:0]  use_count
);

  color_t [SLOT_COUNT-1:0] color_r;
  mult_t  [SLOT_COUNT-1:0] mult_r;
  count_t [SLOT_COUNT-1:0] count_r;

  // Palette and use counts, updated once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        color_r[i] <= base_color(i);
        mult_r[i]  <= MULT_RESET;
        count_r[i] <= '0;
      end
    end else if (apply) begin
      if (upd.clear) begin
        for (int i = 1; i < SLOT_COUNT; i++) begin
          count_r[i] <= '0;
        end
      end
      if (upd.cnt_we) begin
        count_r[upd.cnt_slot] <= upd.cnt_val;
      end
      if (upd.claim) begin
        color_r[upd.cnt_slot] <= upd.color;
        mult_r[upd.cnt_slot]  <= upd.mult;
      end
    end
  end

  assign slot_color = color_r;
  assign slot_mult  = mult_r;
  assign use_count  = count_r;

endmodule

// ----- rtl/light_slot_match_allocator_top.sv -----
// Throughput: one request per cycle while the result channel is not stalled;
// the palette search and the count update of an item finish between the
// input and result registers.
// Reset (synchronous, active low) restores the palette, clears all use
// counts and reloads the configuration.
module light_slot_match_allocator_top
  import lsma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // light_color[23:0], multiplier[31:24], slot[33:32]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // chosen_slot[1:0], count_after[17:2]
  output logic        out_tuser,  // newly_claimed[0]
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  // Configuration registers.
  tol_t  tol_r;
  mult_t dflt_mult_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      dflt_mult_r <= MULT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOL:   tol_r       <= cfg_data;
        REG_DMULT: dflt_mult_r <= cfg_data[7:0];
        default:   tol_r       <= tol_r;
      endcase
    end
  end

  // Pipeline handshake: the input stage moves on when the result register frees.
  logic s1_valid_r;
  req_t s1_req_r;
  logic out_valid_r;
  res_t out_res_r;
  logic adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.kind  <= in_tuser;
      s1_req_r.color <= in_tdata[23:0];
      s1_req_r.mult  <= in_tdata[31:24];
      s1_req_r.slot  <= in_tdata[33:32];
    end
  end

  // Palette search and state.
  color_t [SLOT_COUNT-1:0] slot_color;
  mult_t  [SLOT_COUNT-1:0] slot_mult;
  count_t [SLOT_COUNT-1:0] use_count;
  res_t                    res;
  upd_t                    upd;

  lsma_match u_match (
    .req        (s1_req_r),
    .slot_color (slot_color),
    .slot_mult  (slot_mult),
    .use_count  (use_count),
    .tol        (tol_r),
    .dflt_mult  (dflt_mult_r),
    .res        (res),
    .upd        (upd)
  );

  lsma_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (adv),
    .upd        (upd),
    .slot_color (slot_color),
    .slot_mult  (slot_mult),
    .use_count  (use_count)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.count_after, out_res_r.chosen_slot};
  assign out_tuser  = out_res_r.newly_claimed;

`ifndef SYNTHESIS
  // A freshly claimed slot always reports a count of one.
  a_claim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[17:2] == 16'd1))
    else $error("claimed slot reported a count other than one");

  // After a clear request is processed, every slot but slot 0 is free.
  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_req_r.kind == KIND_CLEAR) |=> (use_count[SLOT_COUNT-1:1] == '0))
    else $error("clear request left a slot in use");

  // An empty input stage always takes a new item.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stage empty but not ready");
`endif

endmodule
